// ===== design/sbcr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and helpers for the swept box collision pipeline
// no dependencies

package sbcr_pkg;

    // slab time magnitude bits below the clamp value
    localparam int QBITS      = 15;
    localparam int T_W        = QBITS + 2;
    localparam int NUM_W      = 26;
    localparam int DIR_W      = 40;
    localparam int FRAC_SHIFT = 30;
    localparam int REM_W      = NUM_W + FRAC_SHIFT;
    localparam int DIV_STAGES = QBITS + 3;
    localparam int RES_STAGES = 5;

    localparam logic signed [T_W-1:0] T_ONE     = 17'sd16384;
    localparam logic signed [T_W-1:0] T_NEG_ONE = -17'sd16384;
    localparam logic signed [T_W-1:0] T_ZERO    = 17'sd0;

    localparam logic signed [1:0] N_POS  = 2'sb01;
    localparam logic signed [1:0] N_NEG  = 2'sb11;
    localparam logic signed [1:0] N_ZERO = 2'sb00;

    typedef struct packed {
        logic signed [23:0]      ml;
        logic signed [23:0]      mt;
        logic        [22:0]      mw;
        logic        [22:0]      mh;
        logic signed [23:0]      vx;
        logic signed [23:0]      vy;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic                    any_vel;
    } pair_t;

    typedef struct packed {
        pair_t                   pair;
        logic signed [NUM_W-1:0] num_nx;
        logic signed [NUM_W-1:0] num_ny;
        logic signed [NUM_W-1:0] num_fx;
        logic signed [NUM_W-1:0] num_fy;
    } setup_t;

    function automatic logic signed [23:0] sat24(input logic signed [27:0] x);
        logic signed [23:0] r;
        if (x > 28'sd8388607)
            r = 24'sd8388607;
        else if (x < -28'sd8388608)
            r = -24'sd8388608;
        else
            r = x[23:0];
        return r;
    endfunction

endpackage

// ===== design/sbcr_setup.sv =====
`timescale 1ns / 1ps
// first stage: sweep direction and the four slab numerators
// depends on sbcr_pkg

module sbcr_setup (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [23:0]   mover_left,
    input  logic signed [23:0]   mover_top,
    input  logic        [22:0]   mover_width,
    input  logic        [22:0]   mover_height,
    input  logic signed [23:0]   vel_x,
    input  logic signed [23:0]   vel_y,
    input  logic        [15:0]   step_time,
    input  logic signed [23:0]   still_left,
    input  logic signed [23:0]   still_top,
    input  logic        [22:0]   still_width,
    input  logic        [22:0]   still_height,
    output sbcr_pkg::setup_t     setup
);

    sbcr_pkg::setup_t setup_reg;
    sbcr_pkg::setup_t setup_next;
    logic signed [40:0] dx_full;
    logic signed [40:0] dy_full;

    always_comb
    begin
        dx_full = vel_x * $signed({1'b0, step_time});
        dy_full = vel_y * $signed({1'b0, step_time});
        setup_next.pair.ml      = mover_left;
        setup_next.pair.mt      = mover_top;
        setup_next.pair.mw      = mover_width;
        setup_next.pair.mh      = mover_height;
        setup_next.pair.vx      = vel_x;
        setup_next.pair.vy      = vel_y;
        setup_next.pair.dx      = dx_full[sbcr_pkg::DIR_W-1:0];
        setup_next.pair.dy      = dy_full[sbcr_pkg::DIR_W-1:0];
        setup_next.pair.any_vel = (vel_x != 24'sd0) || (vel_y != 24'sd0);
        setup_next.num_nx = 26'(still_left) - 26'(mover_left)
                            - $signed({3'b000, mover_width});
        setup_next.num_ny = 26'(still_top) - 26'(mover_top)
                            - $signed({3'b000, mover_height});
        setup_next.num_fx = 26'(still_left) + $signed({3'b000, still_width})
                            - 26'(mover_left);
        setup_next.num_fy = 26'(still_top) + $signed({3'b000, still_height})
                            - 26'(mover_top);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            setup_reg <= setup_next;
    end

    assign setup = setup_reg;

endmodule

// ===== design/sbcr_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider for one slab time, clamped, truncated toward zero
// depends on sbcr_pkg

module sbcr_div (
    input  logic                                clk,
    input  logic [sbcr_pkg::DIV_STAGES-1:0]     en,
    input  logic signed [sbcr_pkg::NUM_W-1:0]   num,
    input  logic signed [sbcr_pkg::DIR_W-1:0]   den,
    output logic signed [sbcr_pkg::T_W-1:0]     t,
    output logic                                invalid
);

    localparam int QB = sbcr_pkg::QBITS;
    localparam int RW = sbcr_pkg::REM_W;
    localparam int DW = sbcr_pkg::DIR_W;
    localparam int NW = sbcr_pkg::NUM_W;

    logic [RW-1:0] rem_reg [0:QB+1];
    logic [DW-1:0] den_reg [0:QB+1];
    logic          neg_reg [0:QB+1];
    logic          inv_reg [0:QB+1];
    logic [QB-1:0] q_reg   [1:QB+1];
    logic          ovf_reg [1:QB+1];

    logic signed [sbcr_pkg::T_W-1:0] t_reg;
    logic                            inv_out_reg;
    logic [NW-1:0]                   num_abs;
    logic [DW-1:0]                   den_abs;
    logic [sbcr_pkg::T_W-1:0]        mag;

    assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_abs = den[DW-1] ? DW'(-den) : DW'(den);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= {num_abs, {sbcr_pkg::FRAC_SHIFT{1'b0}}};
            den_reg[0] <= den_abs;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
            inv_reg[0] <= (num == '0) && (den == '0);
        end
    end

    // quotient at or above the clamp value saturates
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_reg[1] <= rem_reg[0];
            den_reg[1] <= den_reg[0];
            neg_reg[1] <= neg_reg[0];
            inv_reg[1] <= inv_reg[0];
            q_reg[1]   <= '0;
            ovf_reg[1] <= rem_reg[0] >= (RW'(den_reg[0]) << QB);
        end
    end

    for (genvar s = 2; s <= QB + 1; s++)
    begin : g_step
        localparam int B = QB + 1 - s;
        logic [RW:0] trial;

        assign trial = {1'b0, rem_reg[s-1]} - ((RW+1)'(den_reg[s-1]) << B);

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                den_reg[s] <= den_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                inv_reg[s] <= inv_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                if (!trial[RW])
                begin
                    rem_reg[s] <= trial[RW-1:0];
                    q_reg[s]   <= q_reg[s-1] | (QB'(1) << B);
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    q_reg[s]   <= q_reg[s-1];
                end
            end
        end
    end

    assign mag = ovf_reg[QB+1] ? (sbcr_pkg::T_W'(1) << QB) : {2'b00, q_reg[QB+1]};

    always_ff @(posedge clk)
    begin
        if (en[QB+2])
        begin
            t_reg       <= neg_reg[QB+1] ? -$signed(mag) : $signed(mag);
            inv_out_reg <= inv_reg[QB+1];
        end
    end

    assign t       = t_reg;
    assign invalid = inv_out_reg;

endmodule

// ===== design/sbcr_resolve.sv =====
`timescale 1ns / 1ps
// back end: slab intersection, hit test, contact point and velocity push
// depends on sbcr_pkg

module sbcr_resolve (
    input  logic                                clk,
    input  logic [sbcr_pkg::RES_STAGES-1:0]     en,
    input  sbcr_pkg::pair_t                     pair,
    input  logic signed [sbcr_pkg::T_W-1:0]     t_nx,
    input  logic signed [sbcr_pkg::T_W-1:0]     t_ny,
    input  logic signed [sbcr_pkg::T_W-1:0]     t_fx,
    input  logic signed [sbcr_pkg::T_W-1:0]     t_fy,
    input  logic [3:0]                          inv,
    output logic                                hit,
    output logic signed [23:0]                  contact_x,
    output logic signed [23:0]                  contact_y,
    output logic signed [1:0]                   normal_x,
    output logic signed [1:0]                   normal_y,
    output logic signed [15:0]                  hit_time,
    output logic signed [23:0]                  new_vel_x,
    output logic signed [23:0]                  new_vel_y
);

    localparam int TW = sbcr_pkg::T_W;

    // stage 0
    sbcr_pkg::pair_t    pair0_reg;
    logic               ok0_reg;
    logic signed [TW-1:0] nx0_reg, fx0_reg, ny0_reg, fy0_reg;

    // stage 1
    sbcr_pkg::pair_t    pair1_reg;
    logic               hitp1_reg, gtx1_reg, lty1_reg;
    logic signed [TW-1:0] near1_reg, far1_reg;

    // stage 2
    logic               hit2_reg;
    logic signed [1:0]  nrx2_reg, nry2_reg;
    logic signed [15:0] time2_reg;
    logic signed [23:0] vx2_reg, vy2_reg;
    logic signed [55:0] pcx2_reg, pcy2_reg;
    logic [39:0]        pvx2_reg, pvy2_reg;
    logic signed [25:0] c0x2_reg, c0y2_reg;

    // stage 3
    logic               hit3_reg;
    logic signed [1:0]  nrx3_reg, nry3_reg;
    logic signed [15:0] time3_reg;
    logic signed [23:0] vx3_reg, vy3_reg;
    logic signed [26:0] cx3_reg, cy3_reg;
    logic [25:0]        px3_reg, py3_reg;

    // stage 4
    logic               hit_reg;
    logic signed [23:0] cx_reg, cy_reg, nvx_reg, nvy_reg;
    logic signed [1:0]  nrx_reg, nry_reg;
    logic signed [15:0] time_reg;

    logic signed [15:0] t16;
    logic [TW-1:0]      om_full;
    logic [23:0]        magx, magy;
    logic signed [56:0] sumx, sumy;
    logic [39:0]        rpx, rpy;
    logic signed [27:0] vpx, vpy;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pair0_reg <= pair;
            ok0_reg   <= pair.any_vel && (inv == 4'b0000);
            nx0_reg   <= (t_nx > t_fx) ? t_fx : t_nx;
            fx0_reg   <= (t_nx > t_fx) ? t_nx : t_fx;
            ny0_reg   <= (t_ny > t_fy) ? t_fy : t_ny;
            fy0_reg   <= (t_ny > t_fy) ? t_ny : t_fy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pair1_reg <= pair0_reg;
            hitp1_reg <= ok0_reg && !((nx0_reg > fy0_reg) || (ny0_reg > fx0_reg));
            near1_reg <= (nx0_reg > ny0_reg) ? nx0_reg : ny0_reg;
            far1_reg  <= (fx0_reg < fy0_reg) ? fx0_reg : fy0_reg;
            gtx1_reg  <= nx0_reg > ny0_reg;
            lty1_reg  <= nx0_reg < ny0_reg;
        end
    end

    always_comb
    begin
        t16     = $signed(near1_reg[15:0]);
        om_full = TW'(sbcr_pkg::T_ONE - near1_reg);
        magx    = pair1_reg.vx[23] ? 24'(-pair1_reg.vx) : 24'(pair1_reg.vx);
        magy    = pair1_reg.vy[23] ? 24'(-pair1_reg.vy) : 24'(pair1_reg.vy);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hit2_reg  <= hitp1_reg && (far1_reg >= sbcr_pkg::T_ZERO)
                         && (near1_reg <= sbcr_pkg::T_ONE)
                         && (near1_reg >= sbcr_pkg::T_NEG_ONE);
            nrx2_reg  <= gtx1_reg ? (pair1_reg.dx[sbcr_pkg::DIR_W-1] ? sbcr_pkg::N_POS
                                                                     : sbcr_pkg::N_NEG)
                                  : sbcr_pkg::N_ZERO;
            nry2_reg  <= (lty1_reg && !gtx1_reg)
                         ? (pair1_reg.dy[sbcr_pkg::DIR_W-1] ? sbcr_pkg::N_POS
                                                            : sbcr_pkg::N_NEG)
                         : sbcr_pkg::N_ZERO;
            time2_reg <= t16;
            vx2_reg   <= pair1_reg.vx;
            vy2_reg   <= pair1_reg.vy;
            pcx2_reg  <= pair1_reg.dx * t16;
            pcy2_reg  <= pair1_reg.dy * t16;
            pvx2_reg  <= magx * om_full[15:0];
            pvy2_reg  <= magy * om_full[15:0];
            c0x2_reg  <= $signed({pair1_reg.ml[23], pair1_reg.ml, 1'b0})
                         + $signed({3'b000, pair1_reg.mw});
            c0y2_reg  <= $signed({pair1_reg.mt[23], pair1_reg.mt, 1'b0})
                         + $signed({3'b000, pair1_reg.mh});
        end
    end

    // round to nearest, ties up
    always_comb
    begin
        sumx = (57'(c0x2_reg) <<< 29) + 57'(pcx2_reg) + (57'sd1 <<< 29);
        sumy = (57'(c0y2_reg) <<< 29) + 57'(pcy2_reg) + (57'sd1 <<< 29);
        rpx  = pvx2_reg + 40'd8192;
        rpy  = pvy2_reg + 40'd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hit3_reg  <= hit2_reg;
            nrx3_reg  <= nrx2_reg;
            nry3_reg  <= nry2_reg;
            time3_reg <= time2_reg;
            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            cx3_reg   <= sumx[56:30];
            cy3_reg   <= sumy[56:30];
            px3_reg   <= rpx[39:14];
            py3_reg   <= rpy[39:14];
        end
    end

    always_comb
    begin
        case (nrx3_reg)
            sbcr_pkg::N_POS: vpx = 28'(vx3_reg) + $signed({2'b00, px3_reg});
            sbcr_pkg::N_NEG: vpx = 28'(vx3_reg) - $signed({2'b00, px3_reg});
            default:         vpx = 28'(vx3_reg);
        endcase
        case (nry3_reg)
            sbcr_pkg::N_POS: vpy = 28'(vy3_reg) + $signed({2'b00, py3_reg});
            sbcr_pkg::N_NEG: vpy = 28'(vy3_reg) - $signed({2'b00, py3_reg});
            default:         vpy = 28'(vy3_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            hit_reg  <= hit3_reg;
            cx_reg   <= hit3_reg ? sbcr_pkg::sat24(28'(cx3_reg)) : 24'sd0;
            cy_reg   <= hit3_reg ? sbcr_pkg::sat24(28'(cy3_reg)) : 24'sd0;
            nrx_reg  <= hit3_reg ? nrx3_reg : sbcr_pkg::N_ZERO;
            nry_reg  <= hit3_reg ? nry3_reg : sbcr_pkg::N_ZERO;
            time_reg <= hit3_reg ? time3_reg : 16'sd0;
            nvx_reg  <= hit3_reg ? sbcr_pkg::sat24(vpx) : vx3_reg;
            nvy_reg  <= hit3_reg ? sbcr_pkg::sat24(vpy) : vy3_reg;
        end
    end

    assign hit       = hit_reg;
    assign contact_x = cx_reg;
    assign contact_y = cy_reg;
    assign normal_x  = nrx_reg;
    assign normal_y  = nry_reg;
    assign hit_time  = time_reg;
    assign new_vel_x = nvx_reg;
    assign new_vel_y = nvy_reg;

endmodule

// ===== design/swept_box_collision_resolve.sv =====
`timescale 1ns / 1ps
// top level of the swept box collision pipeline
// depends on sbcr_pkg, sbcr_setup, sbcr_div, sbcr_resolve
//
//   channel   direction   handshake             payload
//   in        request in  in_valid / in_stall   mover, velocity, step, still box
//   out       result out  out_valid / out_stall hit, contact, normal, time, velocity
//
// one request per cycle unless the pipeline stalls; 1 setup, 18 divider, 5 resolve stages
// most of the stages are in the one-bit-per-stage slab time dividers
// rst_n clears the stage valid bits only
// each stage holds while the next one is full and held, so bubbles close up

module swept_box_collision_resolve (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] mover_left,
    input  logic signed [23:0] mover_top,
    input  logic        [22:0] mover_width,
    input  logic        [22:0] mover_height,
    input  logic signed [23:0] vel_x,
    input  logic signed [23:0] vel_y,
    input  logic        [15:0] step_time,
    input  logic signed [23:0] still_left,
    input  logic signed [23:0] still_top,
    input  logic        [22:0] still_width,
    input  logic        [22:0] still_height,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [23:0] contact_x,
    output logic signed [23:0] contact_y,
    output logic signed [1:0]  normal_x,
    output logic signed [1:0]  normal_y,
    output logic signed [15:0] hit_time,
    output logic signed [23:0] new_vel_x,
    output logic signed [23:0] new_vel_y
);

    localparam int DS = sbcr_pkg::DIV_STAGES;
    localparam int NS = 1 + DS + sbcr_pkg::RES_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] en;

    sbcr_pkg::setup_t setup;
    sbcr_pkg::pair_t  dly_reg [0:DS-1];

    logic signed [sbcr_pkg::T_W-1:0] t_nx, t_ny, t_fx, t_fy;
    logic [3:0]                      inv;

    assign rdy[NS] = !out_stall;

    for (genvar k = 0; k < NS; k++)
    begin : g_ctl
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
        assign en[k]  = rdy[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            for (int k = 0; k < NS; k++)
                if (en[k])
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[NS-1];

    sbcr_setup u_setup (
        .clk          (clk),
        .en           (en[0]),
        .mover_left   (mover_left),
        .mover_top    (mover_top),
        .mover_width  (mover_width),
        .mover_height (mover_height),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .step_time    (step_time),
        .still_left   (still_left),
        .still_top    (still_top),
        .still_width  (still_width),
        .still_height (still_height),
        .setup        (setup)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
            dly_reg[0] <= setup.pair;
    end

    for (genvar k = 1; k < DS; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en[k+1])
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    sbcr_div u_div_nx (
        .clk (clk), .en (en[DS:1]), .num (setup.num_nx), .den (setup.pair.dx),
        .t (t_nx), .invalid (inv[0])
    );

    sbcr_div u_div_ny (
        .clk (clk), .en (en[DS:1]), .num (setup.num_ny), .den (setup.pair.dy),
        .t (t_ny), .invalid (inv[1])
    );

    sbcr_div u_div_fx (
        .clk (clk), .en (en[DS:1]), .num (setup.num_fx), .den (setup.pair.dx),
        .t (t_fx), .invalid (inv[2])
    );

    sbcr_div u_div_fy (
        .clk (clk), .en (en[DS:1]), .num (setup.num_fy), .den (setup.pair.dy),
        .t (t_fy), .invalid (inv[3])
    );

    sbcr_resolve u_resolve (
        .clk       (clk),
        .en        (en[NS-1:DS+1]),
        .pair      (dly_reg[DS-1]),
        .t_nx      (t_nx),
        .t_ny      (t_ny),
        .t_fx      (t_fx),
        .t_fy      (t_fy),
        .inv       (inv),
        .hit       (hit),
        .contact_x (contact_x),
        .contact_y (contact_y),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .hit_time  (hit_time),
        .new_vel_x (new_vel_x),
        .new_vel_y (new_vel_y)
    );

endmodule

// ===== design/sbcr_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the swept box collision pipeline, bound to the top level
// depends on swept_box_collision_resolve

module sbcr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               hit,
    input logic signed [23:0] contact_x,
    input logic signed [23:0] contact_y,
    input logic signed [1:0]  normal_x,
    input logic signed [1:0]  normal_y,
    input logic signed [15:0] hit_time,
    input logic signed [23:0] new_vel_x,
    input logic signed [23:0] new_vel_y
);

    // a held result keeps its hit flag, contact_x, hit time and new velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(contact_x)
            && $stable(new_vel_x) && $stable(new_vel_y) && $stable(hit_time))
    else $error("held result changed");

    // a miss reports zero contact data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> contact_x == 24'sd0 && contact_y == 24'sd0
            && normal_x == 2'sb00 && normal_y == 2'sb00 && hit_time == 16'sd0)
    else $error("miss with contact data");

    // at most one axis normal, never the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x == 2'sb00 || normal_y == 2'sb00)
            && normal_x != 2'sb10 && normal_y != 2'sb10)
    else $error("bad normal");

    // hit time within one step either way
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> hit_time <= 16'sd16384 && hit_time >= -16'sd16384)
    else $error("hit time out of range");

endmodule

bind swept_box_collision_resolve sbcr_checker u_sbcr_checker (.*);
